FILE: src/domq_pkg.sv
// Shared types and constants for the deadline ordered message queue.
package domq_pkg;

  localparam logic [1:0] CMD_POST   = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_POLL   = 2'd2;

  localparam logic [2:0] ST_POSTED    = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_HALT_REJ  = 3'd2;
  localparam logic [2:0] ST_DELIVERED = 3'd3;
  localparam logic [2:0] ST_NONE_DUE  = 3'd4;
  localparam logic [2:0] ST_REMOVED   = 3'd5;
  localparam logic [2:0] ST_IGNORED   = 3'd6;

  localparam int unsigned  DUE_W     = 48;
  localparam logic [47:0]  DUE_MAX   = 48'hFFFF_FFFF_FFFF;
  localparam logic [9:0]   MS_TO_US  = 10'd1000;

  typedef struct packed {
    logic [47:0] due;
    logic [7:0]  handler;
    logic [31:0] kind;
    logic [63:0] arg_one;
    logic [63:0] arg_two;
  } entry_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;      // latch the input item
    logic calc_due;  // register the saturated due time
    logic scan_rd;   // issue a read at the scan index
    logic ins_step;  // post walk step (uses read data)
    logic rem_step;  // remove walk step
    logic poll_step; // poll walk step
    logic write_new; // write the new entry, or the last displaced one, at the end slot
    logic finish;    // commit the count and emit a result
    logic [2:0] status;
  } ctl_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       full;
    logic       empty;
    logic       scan_done;
    logic       head_due;
  } sts_t;

endpackage

FILE: src/domq_datapath.sv
// Datapath: entry memory, scan pointers, due time arithmetic and result registers.
module domq_datapath
  import domq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ctl_t                  ctl,
  output sts_t                  sts,
  input  logic [1:0]            cmd,
  input  logic [47:0]           now_us,
  input  logic [31:0]           delay_ms,
  input  logic [7:0]            handler_id,
  input  logic signed [31:0]    what_code,
  input  logic [63:0]           arg_one,
  input  logic [63:0]           arg_two,
  output logic                  done,
  output logic [2:0]            status,
  output logic [7:0]            out_handler_id,
  output logic signed [31:0]    out_what,
  output logic [63:0]           out_arg_one,
  output logic [63:0]           out_arg_two,
  output logic [47:0]           out_due_time,
  output logic [5:0]            removed_count,
  output logic [5:0]            queue_count
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  entry_t mem [QUEUE_DEPTH];
  entry_t rd_data;
  entry_t carry;           // entry displaced during an insert shift
  entry_t item;

  logic [1:0]    cmd_q;
  logic [47:0]   now_q;
  logic [31:0]   delay_q;
  logic [41:0]   prod;     // delay_ms * 1000 fits in 42 bits
  logic [48:0]   sum;
  logic [CW-1:0] count;
  logic [CW-1:0] rd_idx;   // index read last cycle
  logic [CW-1:0] scan;     // next index to read
  logic [CW-1:0] wr_idx;   // compaction write pointer for removes
  logic [CW-1:0] gone;
  logic [CW-1:0] gone_total; // matches including the step in progress
  logic [CW-1:0] kept_total; // survivors including the step in progress
  logic          placed;   // insert position already found
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;
  logic          match;

  assign prod = 42'(delay_q) * 42'(MS_TO_US);
  assign sum  = {1'b0, now_q} + 49'(prod);

  always_ff @(posedge clk) begin
    if (ctl.scan_rd) begin
      rd_data <= mem[scan[AW-1:0]];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  assign match = (rd_data.handler == item.handler) && (rd_data.kind == item.kind);

  assign gone_total = gone + CW'(ctl.rem_step && match);
  assign kept_total = wr_idx + CW'(ctl.rem_step && !match);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = wr_idx[AW-1:0];
    wr_data = rd_data;
    if (ctl.ins_step) begin
      wr_en   = 1'b1;
      wr_addr = rd_idx[AW-1:0];
      if (placed) begin
        wr_data = carry;
      end else if (rd_data.due > item.due) begin
        wr_data = item;
      end else begin
        wr_en = 1'b0;
      end
    end else if (ctl.rem_step) begin
      wr_en = !match;
    end else if (ctl.poll_step) begin
      // The head entry leaves; every later entry moves down by one.
      wr_en   = (rd_idx != '0);
      wr_addr = AW'(rd_idx - CW'(1));
    end else if (ctl.write_new) begin
      wr_en   = 1'b1;
      wr_addr = count[AW-1:0];
      wr_data = placed ? carry : item;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q        <= cmd;
      now_q        <= now_us;
      delay_q      <= delay_ms;
      item.handler <= handler_id;
      item.kind    <= what_code;
      item.arg_one <= arg_one;
      item.arg_two <= arg_two;
      scan         <= '0;
      wr_idx       <= '0;
      gone         <= '0;
      placed       <= 1'b0;
    end
    if (ctl.calc_due) begin
      item.due <= sum[48] ? DUE_MAX : sum[47:0];
    end
    if (ctl.scan_rd) begin
      rd_idx <= scan;
      scan   <= scan + CW'(1);
    end
    if (ctl.ins_step) begin
      if (placed || rd_data.due > item.due) begin
        carry  <= rd_data;
        placed <= 1'b1;
      end
    end
    if (ctl.rem_step) begin
      if (match) begin
        gone <= gone + CW'(1);
      end else begin
        wr_idx <= wr_idx + CW'(1);
      end
    end
    if (ctl.poll_step && rd_idx == '0) begin
      out_handler_id <= rd_data.handler;
      out_what       <= rd_data.kind;
      out_arg_one    <= rd_data.arg_one;
      out_arg_two    <= rd_data.arg_two;
      out_due_time   <= rd_data.due;
    end
    if (ctl.finish) begin
      status        <= ctl.status;
      removed_count <= (ctl.status == ST_REMOVED) ? 6'(gone_total) : '0;
      if (ctl.status == ST_POSTED) begin
        out_due_time <= item.due;
      end else if (ctl.status != ST_DELIVERED) begin
        out_due_time <= '0;
      end
      if (ctl.status != ST_DELIVERED) begin
        out_handler_id <= '0;
        out_what       <= '0;
        out_arg_one    <= '0;
        out_arg_two    <= '0;
      end
    end
  end

  logic [CW-1:0] count_next;
  always_comb begin
    count_next = count;
    case (ctl.status)
      ST_POSTED:    count_next = count + CW'(1);
      ST_DELIVERED: count_next = count - CW'(1);
      ST_REMOVED:   count_next = kept_total;
      default:      count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      done        <= 1'b0;
      queue_count <= '0;
    end else begin
      done <= ctl.finish;
      if (ctl.finish) begin
        count       <= count_next;
        queue_count <= 6'(count_next);
      end
    end
  end

  assign sts.cmd       = cmd_q;
  assign sts.full      = (count >= CW'(QUEUE_DEPTH));
  assign sts.empty     = (count == '0);
  assign sts.scan_done = (scan >= count);
  assign sts.head_due  = (now_q >= rd_data.due);

endmodule

FILE: src/domq_ctrl.sv
// Controller state machine sequencing one command over the entry memory.
module domq_ctrl
  import domq_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic halted,
  input  sts_t sts,
  output logic busy,
  output ctl_t ctl
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DEC   = 3'd1;
  localparam logic [2:0] S_INS   = 3'd2;
  localparam logic [2:0] S_REM   = 3'd3;
  localparam logic [2:0] S_PHEAD = 3'd4;
  localparam logic [2:0] S_PSHFT = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0] state, state_next;
  logic       halt_q;

  always_comb begin
    state_next = state;
    ctl        = '0;
    ctl.status = ST_NONE_DUE;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          ctl.load   = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        ctl.calc_due = 1'b1;
        if (sts.cmd == CMD_POST) begin
          if (halt_q) begin
            ctl.finish = 1'b1; ctl.status = ST_HALT_REJ; state_next = S_IDLE;
          end else if (sts.full) begin
            ctl.finish = 1'b1; ctl.status = ST_FULL; state_next = S_IDLE;
          end else if (sts.empty) begin
            state_next = S_FIN;
          end else begin
            ctl.scan_rd = 1'b1; state_next = S_INS;
          end
        end else if (sts.cmd == CMD_REMOVE) begin
          if (halt_q) begin
            ctl.finish = 1'b1; ctl.status = ST_IGNORED; state_next = S_IDLE;
          end else if (sts.empty) begin
            ctl.finish = 1'b1; ctl.status = ST_REMOVED; state_next = S_IDLE;
          end else begin
            ctl.scan_rd = 1'b1; state_next = S_REM;
          end
        end else if (sts.cmd == CMD_POLL) begin
          if (halt_q) begin
            ctl.finish = 1'b1; ctl.status = ST_IGNORED; state_next = S_IDLE;
          end else if (sts.empty) begin
            ctl.finish = 1'b1; state_next = S_IDLE;
          end else begin
            ctl.scan_rd = 1'b1; state_next = S_PHEAD;
          end
        end else begin
          ctl.finish = 1'b1; state_next = S_IDLE;
        end
      end
      S_INS: begin
        ctl.ins_step = 1'b1;
        if (sts.scan_done) begin
          state_next = S_FIN;
        end else begin
          ctl.scan_rd = 1'b1;
        end
      end
      S_FIN: begin
        ctl.write_new = 1'b1;
        ctl.finish    = 1'b1;
        ctl.status    = ST_POSTED;
        state_next    = S_IDLE;
      end
      S_REM: begin
        ctl.rem_step = 1'b1;
        if (sts.scan_done) begin
          ctl.finish = 1'b1; ctl.status = ST_REMOVED; state_next = S_IDLE;
        end else begin
          ctl.scan_rd = 1'b1;
        end
      end
      S_PHEAD: begin
        if (!sts.head_due) begin
          ctl.finish = 1'b1; state_next = S_IDLE;
        end else begin
          ctl.poll_step = 1'b1;
          if (sts.scan_done) begin
            ctl.finish = 1'b1; ctl.status = ST_DELIVERED; state_next = S_IDLE;
          end else begin
            ctl.scan_rd = 1'b1; state_next = S_PSHFT;
          end
        end
      end
      S_PSHFT: begin
        ctl.poll_step = 1'b1;
        if (sts.scan_done) begin
          ctl.finish = 1'b1; ctl.status = ST_DELIVERED; state_next = S_IDLE;
        end else begin
          ctl.scan_rd = 1'b1;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
    if (start && state == S_IDLE) begin
      halt_q <= halted;
    end
  end

  assign busy = (state != S_IDLE);

endmodule

FILE: src/deadline_ordered_message_queue_top.sv
// Top level of the deadline ordered message queue.
//
//   Channel   Handshake          Contents
//   command   start / busy       cmd, now_us, delay_ms, handler_id, what_code, args
//   result    done (one cycle)   status, out_* fields, removed_count, queue_count
//   config    halted_we          halted_wdata
//
// A command transfer takes place when start is high and busy is low. Its
// result appears with done once the controller has finished the command; commands
// that touch no entry finish without reading the entry memory, while posts, removes
// and due polls walk the entry memory with one read per stored entry.
// Reset (rst, synchronous) empties the queue and clears halted.
// The receiver cannot stall; each result is valid for exactly one cycle.
module deadline_ordered_message_queue_top
  import domq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         cmd,
  input  logic [47:0]        now_us,
  input  logic [31:0]        delay_ms,
  input  logic [7:0]         handler_id,
  input  logic signed [31:0] what_code,
  input  logic [63:0]        arg_one,
  input  logic [63:0]        arg_two,
  input  logic               halted_we,
  input  logic               halted_wdata,
  output logic               done,
  output logic [2:0]         status,
  output logic [7:0]         out_handler_id,
  output logic signed [31:0] out_what,
  output logic [63:0]        out_arg_one,
  output logic [63:0]        out_arg_two,
  output logic [47:0]        out_due_time,
  output logic [5:0]         removed_count,
  output logic [5:0]         queue_count
);

  ctl_t ctl;
  sts_t sts;
  logic halted;

  // The user must change the halted register only while no transfer is in progress; the block does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      halted <= 1'b0;
    end else if (halted_we) begin
      halted <= halted_wdata;
    end
  end

  domq_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .halted (halted),
    .sts    (sts),
    .busy   (busy),
    .ctl    (ctl)
  );

  domq_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl),
    .sts            (sts),
    .cmd            (cmd),
    .now_us         (now_us),
    .delay_ms       (delay_ms),
    .handler_id     (handler_id),
    .what_code      (what_code),
    .arg_one        (arg_one),
    .arg_two        (arg_two),
    .done           (done),
    .status         (status),
    .out_handler_id (out_handler_id),
    .out_what       (out_what),
    .out_arg_one    (out_arg_one),
    .out_arg_two    (out_arg_two),
    .out_due_time   (out_due_time),
    .removed_count  (removed_count),
    .queue_count    (queue_count)
  );

endmodule

FILE: verif/deadline_ordered_message_queue_top_tb.sv
// Testbench for the deadline ordered message queue: directed and random commands checked against a queue model.
`timescale 1ns / 1ps

module deadline_ordered_message_queue_top_tb;
  import domq_pkg::*;

  localparam int DEPTH = 32;
  localparam int WATCHDOG_LIMIT = 5000;
  // cmd value 3 is not a defined command; the block answers it with none due.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // One result transfer as the block should produce it.
  typedef struct {
    logic [2:0]  status;
    logic [7:0]  hid;
    logic [31:0] what;
    logic [63:0] a1;
    logic [63:0] a2;
    logic [47:0] due;
    logic [5:0]  removed;
    logic [5:0]  count;
  } result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0] cmd = '0;
  logic [47:0] now_us = '0;
  logic [31:0] delay_ms = '0;
  logic [7:0] handler_id = '0;
  logic signed [31:0] what_code = '0;
  logic [63:0] arg_one = '0;
  logic [63:0] arg_two = '0;
  logic halted_we = 1'b0;
  logic halted_wdata = 1'b0;
  logic done;
  logic [2:0] status;
  logic [7:0] out_handler_id;
  logic signed [31:0] out_what;
  logic [63:0] out_arg_one;
  logic [63:0] out_arg_two;
  logic [47:0] out_due_time;
  logic [5:0] removed_count;
  logic [5:0] queue_count;

  always #5 clk = ~clk;

  deadline_ordered_message_queue_top #(.QUEUE_DEPTH(DEPTH)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd), .now_us(now_us),
    .delay_ms(delay_ms), .handler_id(handler_id), .what_code(what_code),
    .arg_one(arg_one), .arg_two(arg_two), .halted_we(halted_we),
    .halted_wdata(halted_wdata), .done(done), .status(status),
    .out_handler_id(out_handler_id), .out_what(out_what), .out_arg_one(out_arg_one),
    .out_arg_two(out_arg_two), .out_due_time(out_due_time),
    .removed_count(removed_count), .queue_count(queue_count)
  );

  // Shadow copy of the message queue, kept in due-time order.
  entry_t  shadow_q[$];
  logic    shadow_halted = 1'b0;
  result_t pending_results[$];

  int errors = 0;
  int sent = 0;
  int delivered_seen = 0;
  int full_seen = 0;
  int removed_total = 0;
  int idle_cycles = 0;
  logic [47:0] clock_us = '0;

  // Applies one command to the shadow queue and returns the result it yields.
  function automatic result_t queue_apply(logic [1:0] c, logic [47:0] now, logic [31:0] dly,
                                          logic [7:0] hid, logic [31:0] what,
                                          logic [63:0] a1, logic [63:0] a2);
    result_t r;
    entry_t e;
    logic [48:0] sum;
    int pos;
    int gone;
    r = '{default: '0};
    r.status = ST_NONE_DUE;
    case (c)
      CMD_POST: begin
        if (shadow_halted) begin
          r.status = ST_HALT_REJ;
        end else if (shadow_q.size() >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          sum = {1'b0, now} + 49'(dly) * 49'(MS_TO_US);
          e.due = sum[48] ? DUE_MAX : sum[47:0];
          e.handler = hid;
          e.kind = what;
          e.arg_one = a1;
          e.arg_two = a2;
          pos = 0;
          while (pos < shadow_q.size() && shadow_q[pos].due <= e.due) pos++;
          shadow_q.insert(pos, e);
          r.status = ST_POSTED;
          r.due = e.due;
        end
      end
      CMD_REMOVE: begin
        if (shadow_halted) begin
          r.status = ST_IGNORED;
        end else begin
          gone = 0;
          for (int i = shadow_q.size() - 1; i >= 0; i--) begin
            if (shadow_q[i].handler == hid && shadow_q[i].kind == what) begin
              shadow_q.delete(i);
              gone++;
            end
          end
          r.status = ST_REMOVED;
          r.removed = 6'(gone);
        end
      end
      CMD_POLL: begin
        if (shadow_halted) begin
          r.status = ST_IGNORED;
        end else if (shadow_q.size() > 0 && now >= shadow_q[0].due) begin
          e = shadow_q.pop_front();
          r.status = ST_DELIVERED;
          r.hid = e.handler;
          r.what = e.kind;
          r.a1 = e.arg_one;
          r.a2 = e.arg_two;
          r.due = e.due;
        end
      end
      default: r.status = ST_NONE_DUE;
    endcase
    r.count = 6'(shadow_q.size());
    return r;
  endfunction

  // Sends one command after a random gap; the model is updated at the transfer.
  // Start stays high after the transfer until the next gap or a drain lowers it.
  task automatic send_command(logic [1:0] c, logic [47:0] now, logic [31:0] dly,
                              logic [7:0] hid, logic [31:0] what,
                              logic [63:0] a1, logic [63:0] a2);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd <= c;
    now_us <= now;
    delay_ms <= dly;
    handler_id <= hid;
    what_code <= what;
    arg_one <= a1;
    arg_two <= a2;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    // The transfer happened at this edge.
    pending_results.push_back(queue_apply(c, now, dly, hid, what, a1, a2));
    sent++;
  endtask

  // Lowers start, waits for every outstanding result, then lets the block settle.
  task automatic drain;
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);
  endtask

  // Writes the halted register while the block is idle.
  task automatic write_halted(logic value);
    drain();
    halted_we <= 1'b1;
    halted_wdata <= value;
    @(posedge clk);
    halted_we <= 1'b0;
    shadow_halted = value;
  endtask

  // Result checker: every done cycle is compared with the oldest expectation.
  always @(posedge clk) begin
    result_t x;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected, status %0d", $time, status);
        errors++;
      end else begin
        x = pending_results.pop_front();
        if (status == ST_DELIVERED) delivered_seen++;
        if (status == ST_FULL) full_seen++;
        removed_total += removed_count;
        if (status !== x.status || out_handler_id !== x.hid || out_what !== x.what ||
            out_arg_one !== x.a1 || out_arg_two !== x.a2 || out_due_time !== x.due ||
            removed_count !== x.removed || queue_count !== x.count) begin
          $display("%0t: mismatch expected st=%0d h=%0h w=%0h a1=%0h a2=%0h due=%0h rm=%0d n=%0d",
                   $time, x.status, x.hid, x.what, x.a1, x.a2, x.due, x.removed, x.count);
          $display("%0t:            actual st=%0d h=%0h w=%0h a1=%0h a2=%0h due=%0h rm=%0d n=%0d",
                   $time, status, out_handler_id, out_what, out_arg_one, out_arg_two,
                   out_due_time, removed_count, queue_count);
          errors++;
        end
      end
    end
  end

  // Watchdog: counts cycles in which neither a command nor a result moves.
  always @(posedge clk) begin
    if ((start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Extremes of every field, the unused command, saturation, ties and no-match removes.
  task automatic test_directed;
    send_command(CMD_POLL, 48'd0, 32'd0, 8'd0, 32'd0, '0, '0);
    send_command(CMD_REMOVE, 48'd0, 32'd0, 8'd0, 32'd0, '0, '0);
    send_command(CMD_POST, DUE_MAX, 32'hFFFF_FFFF, 8'hFF, 32'h8000_0000, '1, '1);
    send_command(CMD_POST, 48'd0, 32'hFFFF_FFFF, 8'h00, 32'h7FFF_FFFF, '0, '1);
    send_command(CMD_POST, 48'd5, 32'd0, 8'h11, 32'd1, 64'h1, 64'h2);
    send_command(CMD_POST, 48'd5, 32'd0, 8'h22, 32'd1, 64'h3, 64'h4);
    send_command(CMD_POST, 48'd1, 32'd0, 8'h33, 32'hFFFF_FFFF, 64'h5, 64'h6);
    send_command(CMD_POLL, 48'd0, 32'd0, 8'd0, 32'd0, '0, '0);
    send_command(CMD_UNUSED, '1, '1, '1, '1, '1, '1);
    send_command(CMD_POLL, 48'd5, 32'd0, 8'd0, 32'd0, '0, '0);
    send_command(CMD_POLL, 48'd5, 32'd0, 8'd0, 32'd0, '0, '0);
    send_command(CMD_REMOVE, 48'd0, 32'd0, 8'h77, 32'd9, '0, '0);
    send_command(CMD_REMOVE, 48'd0, 32'd0, 8'hFF, 32'h8000_0000, '0, '0);
    send_command(CMD_POLL, DUE_MAX, 32'd0, 8'd0, 32'd0, '0, '0);
    send_command(CMD_POLL, DUE_MAX, 32'd0, 8'd0, 32'd0, '0, '0);
    send_command(CMD_POLL, DUE_MAX, 32'd0, 8'd0, 32'd0, '0, '0);
  endtask

  // Fills past capacity to hit the full case, then empties with a matching remove.
  task automatic test_full_queue;
    for (int i = 0; i < DEPTH + 2; i++)
      send_command(CMD_POST, 48'(i), 32'($urandom_range(0, 3)), 8'h5A, 32'h1234,
                   {$urandom, $urandom}, {$urandom, $urandom});
    send_command(CMD_REMOVE, 48'd0, 32'd0, 8'h5A, 32'h1234, '0, '0);
  endtask

  // While halted posts are rejected, removes and polls are ignored, and the queue stays put.
  task automatic test_halted;
    send_command(CMD_POST, 48'd9, 32'd1, 8'h01, 32'd2, '0, '0);
    write_halted(1'b1);
    send_command(CMD_POST, 48'd0, 32'd0, 8'h01, 32'd2, '0, '0);
    send_command(CMD_REMOVE, 48'd0, 32'd0, 8'h01, 32'd2, '0, '0);
    send_command(CMD_POLL, DUE_MAX, 32'd0, 8'd0, 32'd0, '0, '0);
    send_command(CMD_UNUSED, 48'd0, 32'd0, 8'd0, 32'd0, '0, '0);
    write_halted(1'b0);
    send_command(CMD_POLL, DUE_MAX, 32'd0, 8'd0, 32'd0, '0, '0);
  endtask

  // Random traffic with a rising clock, small handler and kind pools so removes hit.
  task automatic test_random(int n);
    logic [1:0] c;
    logic [47:0] now;
    logic [31:0] dly;
    logic [31:0] what;
    int pick;
    for (int i = 0; i < n; i++) begin
      if (i % 300 == 150) write_halted(1'($urandom_range(0, 1)));
      if (i % 300 == 200) write_halted(1'b0);
      clock_us += 48'($urandom_range(0, 3000));
      pick = $urandom_range(0, 99);
      c = pick < 45 ? CMD_POST : pick < 60 ? CMD_REMOVE : pick < 97 ? CMD_POLL : CMD_UNUSED;
      now = $urandom_range(0, 49) == 0 ? 48'({$urandom, $urandom}) : clock_us;
      dly = $urandom_range(0, 19) == 0 ? $urandom : 32'($urandom_range(0, 5));
      what = $urandom_range(0, 9) == 0 ? $urandom : 32'($urandom_range(0, 3)) - 32'd2;
      send_command(c, now, dly,
                   $urandom_range(0, 9) == 0 ? 8'($urandom) : 8'($urandom_range(0, 3)),
                   what, {$urandom, $urandom}, {$urandom, $urandom});
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_full_queue();
    test_halted();
    test_random(1150);
    drain();
    $display("Sent %0d commands: %0d deliveries, %0d full rejects, %0d entries removed.",
             sent, delivered_seen, full_seen, removed_total);
    $display("Covered post ordering and saturation, remove, poll, halt and the unused command.");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
